@@ src/pnmtd_pkg.sv @@
package pnmtd_pkg;

    // Parser phases
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_WAIT   = 3'd0;
    localparam logic [PH_W-1:0] PH_TYPE   = 3'd1;
    localparam logic [PH_W-1:0] PH_SKIP   = 3'd2;
    localparam logic [PH_W-1:0] PH_WIDTH  = 3'd3;
    localparam logic [PH_W-1:0] PH_HEIGHT = 3'd4;
    localparam logic [PH_W-1:0] PH_MAXVAL = 3'd5;
    localparam logic [PH_W-1:0] PH_PIXELS = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // Field widths
    localparam int TYPE_W  = 4;
    localparam int DIM_W   = 13;
    localparam int CH_W    = 16;
    localparam int IDX_W   = 24;
    localparam int TDATA_W = 120;

    localparam int MAX_DIM_DEF    = 4096;
    localparam int VALUE_BITS_DEF = 16;

    // Bitmap pixels: a zero bit is white.
    localparam logic [CH_W-1:0] BIT_WHITE = 16'd255;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TYPE_W-1:0] image_type;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [CH_W-1:0]   max_gray;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [IDX_W-1:0]  pixel_index;
        logic              last_pixel;
    } t_result;

endpackage

@@ src/pnmtd_parse.sv @@
module pnmtd_parse #(
    parameter int MAX_DIM    = pnmtd_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = pnmtd_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_char,
    input  logic                i_first,
    input  logic                i_eof,
    output logic                o_res_valid,
    output pnmtd_pkg::t_result  o_res
);

    localparam int PW  = pnmtd_pkg::PH_W;
    localparam int TW  = pnmtd_pkg::TYPE_W;
    localparam int DW  = pnmtd_pkg::DIM_W;
    localparam int CW  = pnmtd_pkg::CH_W;
    localparam int XW  = pnmtd_pkg::IDX_W;
    localparam int VB  = VALUE_BITS;
    localparam int AW  = VALUE_BITS + 4;
    localparam int CLW = 17;
    localparam logic [AW-1:0]  VMAX     = AW'((33'd1 << VALUE_BITS) - 33'd1);
    localparam logic [CLW-1:0] DIM_LIM  = CLW'(MAX_DIM);

    logic [PW-1:0] r_phase, n_phase;
    logic [TW-1:0] r_type, n_type;
    logic [DW-1:0] r_width, n_width;
    logic [DW-1:0] r_height, n_height;
    logic [VB-1:0] r_maxval, n_maxval;
    logic [VB-1:0] r_acc, n_acc;
    logic          r_tok, n_tok;
    logic          r_in_comment, n_in_comment;
    logic [1:0]    r_chan, n_chan;
    logic [VB-1:0] r_held_red, n_held_red;
    logic [VB-1:0] r_held_green, n_held_green;
    logic [DW-1:0] r_col, n_col;
    logic [DW-1:0] r_row, n_row;
    logic [XW-1:0] r_pix_idx, n_pix_idx;

    logic          is_digit;
    logic          is_sep;
    logic [3:0]    dval;
    logic [AW-1:0] acc_mul;
    logic [VB-1:0] acc_sat;
    logic          finish;
    logic [VB-1:0] fin_v;
    logic [DW-1:0] fin_dim;
    logic          row_end;
    logic          col_end;

    assign is_digit = (i_char >= pnmtd_pkg::CH_ZERO) && (i_char <= pnmtd_pkg::CH_NINE);
    assign is_sep   = (i_char == pnmtd_pkg::CH_SPACE) || (i_char == pnmtd_pkg::CH_LF);
    assign dval     = 4'(i_char - pnmtd_pkg::CH_ZERO);

    // acc * 10 + digit as two shifted adds, then saturate.
    assign acc_mul = AW'({r_acc, 3'b000}) + AW'({r_acc, 1'b0}) + AW'(dval);
    assign acc_sat = (acc_mul > VMAX) ? VMAX[VB-1:0] : acc_mul[VB-1:0];

    // A token ends on a separator, or on a digit that is the last byte.
    assign finish  = !r_in_comment && ((is_digit && i_eof) || (is_sep && r_tok));
    assign fin_v   = is_digit ? acc_sat : r_acc;
    assign fin_dim = (CLW'(fin_v) > DIM_LIM) ? DW'(DIM_LIM) : DW'(fin_v);

    assign row_end = ({1'b0, r_row} + (DW+1)'(1)) >= {1'b0, r_height};
    assign col_end = ({1'b0, r_col} + (DW+1)'(1)) >= {1'b0, r_width};

    always_comb begin
        n_phase      = r_phase;
        n_type       = r_type;
        n_width      = r_width;
        n_height     = r_height;
        n_maxval     = r_maxval;
        n_acc        = r_acc;
        n_tok        = r_tok;
        n_in_comment = r_in_comment;
        n_chan       = r_chan;
        n_held_red   = r_held_red;
        n_held_green = r_held_green;
        n_col        = r_col;
        n_row        = r_row;
        n_pix_idx    = r_pix_idx;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_first) begin
            n_phase      = pnmtd_pkg::PH_TYPE;
            n_type       = '0;
            n_width      = '0;
            n_height     = '0;
            n_maxval     = '0;
            n_acc        = '0;
            n_tok        = 1'b0;
            n_in_comment = 1'b0;
            n_chan       = '0;
            n_held_red   = '0;
            n_held_green = '0;
            n_col        = '0;
            n_row        = '0;
            n_pix_idx    = '0;
        end else begin
            case (r_phase)
                pnmtd_pkg::PH_TYPE: begin
                    if (is_digit) begin
                        n_type  = dval;
                        n_phase = pnmtd_pkg::PH_SKIP;
                    end else begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = pnmtd_pkg::KIND_ERROR;
                        o_res.image_type = r_type;
                        n_phase          = pnmtd_pkg::PH_WAIT;
                    end
                end
                pnmtd_pkg::PH_SKIP: begin
                    n_phase = pnmtd_pkg::PH_WIDTH;
                end
                pnmtd_pkg::PH_WIDTH, pnmtd_pkg::PH_HEIGHT,
                pnmtd_pkg::PH_MAXVAL, pnmtd_pkg::PH_PIXELS: begin
                    if (r_in_comment) begin
                        if (i_char == pnmtd_pkg::CH_LF) begin
                            n_in_comment = 1'b0;
                        end
                    end else if (is_digit) begin
                        n_acc = acc_sat;
                        n_tok = 1'b1;
                    end else if (is_sep) begin
                        n_tok = r_tok;
                    end else if ((i_char == pnmtd_pkg::CH_HASH) &&
                                 (r_phase == pnmtd_pkg::PH_WIDTH) && !r_tok) begin
                        n_in_comment = 1'b1;
                    end else begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = pnmtd_pkg::KIND_ERROR;
                        o_res.image_type = r_type;
                        n_phase          = pnmtd_pkg::PH_WAIT;
                    end

                    if (finish) begin
                        n_acc = '0;
                        n_tok = 1'b0;
                        case (r_phase)
                            pnmtd_pkg::PH_WIDTH: begin
                                n_width = fin_dim;
                                n_phase = pnmtd_pkg::PH_HEIGHT;
                            end
                            pnmtd_pkg::PH_HEIGHT, pnmtd_pkg::PH_MAXVAL: begin
                                if (r_phase == pnmtd_pkg::PH_HEIGHT) begin
                                    n_height = fin_dim;
                                end else begin
                                    n_maxval = fin_v;
                                end
                                if ((r_phase == pnmtd_pkg::PH_HEIGHT) && (r_type != 4'd1)) begin
                                    n_phase = pnmtd_pkg::PH_MAXVAL;
                                end else begin
                                    o_res_valid        = 1'b1;
                                    o_res.kind         = pnmtd_pkg::KIND_HEADER;
                                    o_res.image_type   = r_type;
                                    o_res.image_width  = n_width;
                                    o_res.image_height = n_height;
                                    o_res.max_gray     = CW'(n_maxval);
                                    if ((r_type inside {[4'd1:4'd3]}) &&
                                        (n_width != '0) && (n_height != '0)) begin
                                        n_phase = pnmtd_pkg::PH_PIXELS;
                                    end else begin
                                        n_phase = pnmtd_pkg::PH_WAIT;
                                    end
                                end
                            end
                            pnmtd_pkg::PH_PIXELS: begin
                                if ((r_type == 4'd3) && (r_chan == 2'd0)) begin
                                    n_held_red = fin_v;
                                    n_chan     = 2'd1;
                                end else if ((r_type == 4'd3) && (r_chan == 2'd1)) begin
                                    n_held_green = fin_v;
                                    n_chan       = 2'd2;
                                end else begin
                                    n_chan            = 2'd0;
                                    o_res_valid       = 1'b1;
                                    o_res.kind        = pnmtd_pkg::KIND_PIXEL;
                                    o_res.image_type  = r_type;
                                    o_res.pixel_index = r_pix_idx;
                                    o_res.last_pixel  = row_end && col_end;
                                    if (r_type == 4'd3) begin
                                        o_res.red   = CW'(r_held_red);
                                        o_res.green = CW'(r_held_green);
                                        o_res.blue  = CW'(fin_v);
                                    end else if (r_type == 4'd1) begin
                                        o_res.red   = (fin_v == '0) ? pnmtd_pkg::BIT_WHITE : '0;
                                        o_res.green = o_res.red;
                                        o_res.blue  = o_res.red;
                                    end else begin
                                        o_res.red   = CW'(fin_v);
                                        o_res.green = CW'(fin_v);
                                        o_res.blue  = CW'(fin_v);
                                    end
                                    n_pix_idx = r_pix_idx + XW'(1);
                                    if (row_end && col_end) begin
                                        n_phase = pnmtd_pkg::PH_WAIT;
                                    end else if (col_end) begin
                                        n_col = '0;
                                        n_row = r_row + DW'(1);
                                    end else begin
                                        n_col = r_col + DW'(1);
                                    end
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (i_eof) begin
            n_phase = pnmtd_pkg::PH_WAIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= pnmtd_pkg::PH_WAIT;
            r_type       <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_maxval     <= '0;
            r_acc        <= '0;
            r_tok        <= 1'b0;
            r_in_comment <= 1'b0;
            r_chan       <= '0;
            r_held_red   <= '0;
            r_held_green <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_pix_idx    <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_type       <= n_type;
            r_width      <= n_width;
            r_height     <= n_height;
            r_maxval     <= n_maxval;
            r_acc        <= n_acc;
            r_tok        <= n_tok;
            r_in_comment <= n_in_comment;
            r_chan       <= n_chan;
            r_held_red   <= n_held_red;
            r_held_green <= n_held_green;
            r_col        <= n_col;
            r_row        <= n_row;
            r_pix_idx    <= n_pix_idx;
        end
    end

endmodule

@@ src/plain_pnm_text_decoder.sv @@
// Plain text PNM decoder (types P1, P2 and P3).
// The slave channel takes one byte of the file per word: tdata carries the byte, tuser
// flags the first byte of a file (it restarts the parser) and tlast flags the last byte
// (it completes a pending token and stops the parser until the next first byte).
// The master channel gives one word for the header, then one word per pixel; tuser
// holds the kind (header, pixel or malformed-token error) and tlast marks the final
// pixel. A malformed byte produces one error word and halts parsing until a new file.
// Throughput is one byte per clock cycle while the spare word is empty: the whole
// step of the parser is a single pass of combinational logic from the parser registers
// to the result register. A result caused by a byte is registered at the edge that
// accepts it: in the output register, or in the spare word if the output is stalled.
// The output stage holds the result register plus one spare word. When the receiver
// stalls, bytes are still taken until one of them produces a result; that result goes
// to the spare word, and the slave tready then drops until the receiver drains it, so
// nothing is lost.
// A synchronous active-low reset clears the parser to wait for a first byte and
// empties both output words.
module plain_pnm_text_decoder #(
    parameter int MAX_DIM    = pnmtd_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = pnmtd_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // char_byte
    input  logic [0:0]                      s_axis_tuser,  // first_byte
    input  logic                            s_axis_tlast,  // end_of_file
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // image_type, image_width, image_height, max_gray, red, green, blue,
    // pixel_index, two zero bits
    output logic [pnmtd_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                      m_axis_tuser,  // kind
    output logic                            m_axis_tlast   // last_pixel
);

    logic               in_fire;
    logic               res_valid;
    pnmtd_pkg::t_result res;

    // Output register and the spare (skid) word behind it.
    logic               r_out_v;
    pnmtd_pkg::t_result r_out;
    logic               r_skid_v;
    pnmtd_pkg::t_result r_skid;

    // The slave side is only held off while the spare word is occupied.
    assign s_axis_tready = !r_skid_v;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    pnmtd_parse #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_fire),
        .i_char      (s_axis_tdata),
        .i_first     (s_axis_tuser[0]),
        .i_eof       (s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The output register reloads whenever it is empty or being taken. The spare word
    // has priority, since it holds the older result. A result that arrives while the
    // output is stalled parks in the spare word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= in_fire && res_valid;
            end
        end else if (in_fire && res_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || m_axis_tready) begin
            r_out <= r_skid_v ? r_skid : res;
        end
        if (!r_skid_v) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last_pixel;
    assign m_axis_tdata  = {2'b00, r_out.pixel_index, r_out.blue, r_out.green, r_out.red,
                            r_out.max_gray, r_out.image_height, r_out.image_width,
                            r_out.image_type};

    // The spare word is never occupied while the output register is empty.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("spare word valid while output register is empty");

    // The spare word only fills when the output was stalled at that edge.
    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !m_axis_tready))
        else $error("spare word filled without a stalled output");

    // Only pixel words can carry the last-pixel mark.
    a_last_on_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == pnmtd_pkg::KIND_PIXEL))
        else $error("last-pixel mark on a non-pixel word");

endmodule
